FILE: hw/rtl/gcl_pkg.sv
// Package of shared widths, register codes and defaults for the grid cell locator.
package gcl_pkg;

  localparam int LAT_W = 30;
  localparam int LON_W = 31;
  localparam int AXIS_W = 31;
  localparam int DEF_INDEX_BITS = 13;
  localparam int CFG_AW = 5;
  localparam logic [12:0] POINTS_RESET = 13'd1200;

  typedef enum logic [2:0] {
    REG_SOUTH_LAT  = 3'd0,
    REG_WEST_LON   = 3'd1,
    REG_NORTH_LAT  = 3'd2,
    REG_EAST_LON   = 3'd3,
    REG_LAT_POINTS = 3'd4,
    REG_LON_POINTS = 3'd5
  } reg_idx_t;

endpackage

FILE: hw/rtl/gcl_axis.sv
// One axis of the locator: multiply, then index and offset dividers, one bit a stage.
module gcl_axis
  import gcl_pkg::*;
#(
  parameter int W  = AXIS_W,
  parameter int IB = DEF_INDEX_BITS
) (
  input  logic          clk,
  input  logic          en,
  input  logic [W-1:0]  d,
  input  logic [W-1:0]  span,
  input  logic [IB-1:0] pts,
  output logic [IB-1:0] idx,
  output logic [W-1:0]  off
);

  logic [W+IB-1:0] prod_r;

  // index divider state, stage k holds the result after k+1 bits
  logic [W-1:0]  rem1_r [IB];
  logic [IB-1:0] low1_r [IB];
  logic [IB-1:0] q1_r   [IB];

  // offset divider state
  logic [IB-1:0] pr2_r  [W];
  logic [W-1:0]  dd2_r  [W];
  logic [W-1:0]  q2_r   [W];
  logic [IB-1:0] idx2_r [W];

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= {{IB{1'b0}}, d} * {{W{1'b0}}, pts};
    end
  end

  for (genvar k = 0; k < IB; k++) begin : g_div1
    logic [W-1:0]  rem_in;
    logic [IB-1:0] low_in;
    logic [IB-1:0] q_in;
    logic [W:0]    trial;
    logic          take;
    if (k == 0) begin : g_first
      assign rem_in = prod_r[W+IB-1:IB];
      assign low_in = prod_r[IB-1:0];
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem1_r[k-1];
      assign low_in = low1_r[k-1];
      assign q_in   = q1_r[k-1];
    end
    assign trial = {rem_in, low_in[IB-1]};
    assign take  = trial >= {1'b0, span};
    always_ff @(posedge clk) begin
      if (en) begin
        rem1_r[k] <= take ? W'(trial - {1'b0, span}) : trial[W-1:0];
        low1_r[k] <= {low_in[IB-2:0], 1'b0};
        q1_r[k]   <= {q_in[IB-2:0], take};
      end
    end
  end

  for (genvar j = 0; j < W; j++) begin : g_div2
    logic [IB-1:0] pr_in;
    logic [W-1:0]  dd_in;
    logic [W-1:0]  q_in;
    logic [IB-1:0] idx_in;
    logic [IB:0]   trial;
    logic          take;
    if (j == 0) begin : g_first
      assign pr_in  = '0;
      assign dd_in  = rem1_r[IB-1];
      assign q_in   = '0;
      assign idx_in = q1_r[IB-1];
    end else begin : g_next
      assign pr_in  = pr2_r[j-1];
      assign dd_in  = dd2_r[j-1];
      assign q_in   = q2_r[j-1];
      assign idx_in = idx2_r[j-1];
    end
    assign trial = {pr_in, dd_in[W-1]};
    assign take  = trial >= {1'b0, pts};
    always_ff @(posedge clk) begin
      if (en) begin
        pr2_r[j]  <= take ? IB'(trial - {1'b0, pts}) : trial[IB-1:0];
        dd2_r[j]  <= {dd_in[W-2:0], 1'b0};
        q2_r[j]   <= {q_in[W-2:0], take};
        idx2_r[j] <= idx_in;
      end
    end
  end

  // zero span or zero count: the axis reads as zero
  logic degen;
  assign degen = (span == '0) || (pts == '0);
  assign idx = degen ? '0 : idx2_r[W-1];
  assign off = degen ? '0 : q2_r[W-1];

endmodule

FILE: hw/rtl/grid_cell_locator_top.sv
// Top level of the grid cell locator: config registers, box test and two axis pipelines.
//
// Usage: a request on the in_ stream carries one point, latitude and longitude in
// signed fixed point. The block tests it against the box held in the cfg_ registers,
// edges included, and returns one result per request on the out_ stream: the cell
// index along each axis, floor((p - sw) * points / span), and the offset from the
// start of that cell. out_tuser is the inside flag; outside points give all zeros.
// The pipeline runs the box test, then the multiply, then one bit of the index
// quotient per stage, then one bit of the offset quotient per stage. Throughput is
// one request per cycle while out_tready does not stall the output, set by the
// one-bit-per-stage dividers which are fully pipelined.
// A stall on out_tready freezes the whole pipeline in place and drops in_tready;
// nothing is lost or repeated. Reset clears the valid bits and sets the box to zero
// and both point counts to 1200. Write configuration only while the block is idle.
module grid_cell_locator_top
  import gcl_pkg::*;
#(
  parameter int INDEX_BITS = DEF_INDEX_BITS,
  localparam int FIELDS_W = 2 * INDEX_BITS + LAT_W + LON_W,
  localparam int OUT_W    = ((FIELDS_W + 7) / 8) * 8
) (
  input  logic                clk,
  input  logic                rst_n,
  // APB configuration port
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [CFG_AW-1:0]   cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready,
  // input stream
  input  logic                in_tvalid,
  output logic                in_tready,
  // in_tdata from bit 0: point_lat[29:0], point_lon[30:0], zero pad
  input  logic [63:0]         in_tdata,
  // output stream
  output logic                out_tvalid,
  input  logic                out_tready,
  // out_tdata from bit 0: lat_index, lon_index, lat_off[29:0], lon_off[30:0], pad
  output logic [OUT_W-1:0]    out_tdata,
  // out_tuser: inside_res
  output logic                out_tuser
);

  localparam int DEPTH    = INDEX_BITS + AXIS_W + 2;

  // configuration registers
  logic signed [LAT_W-1:0]  south_lat_r, north_lat_r;
  logic signed [LON_W-1:0]  west_lon_r, east_lon_r;
  logic [INDEX_BITS-1:0]    lat_points_r, lon_points_r;

  logic     cfg_wr;
  reg_idx_t cfg_idx;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      south_lat_r  <= '0;
      north_lat_r  <= '0;
      west_lon_r   <= '0;
      east_lon_r   <= '0;
      lat_points_r <= INDEX_BITS'(POINTS_RESET);
      lon_points_r <= INDEX_BITS'(POINTS_RESET);
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_SOUTH_LAT:  south_lat_r  <= cfg_pwdata[LAT_W-1:0];
        REG_WEST_LON:   west_lon_r   <= cfg_pwdata[LON_W-1:0];
        REG_NORTH_LAT:  north_lat_r  <= cfg_pwdata[LAT_W-1:0];
        REG_EAST_LON:   east_lon_r   <= cfg_pwdata[LON_W-1:0];
        REG_LAT_POINTS: lat_points_r <= cfg_pwdata[INDEX_BITS-1:0];
        REG_LON_POINTS: lon_points_r <= cfg_pwdata[INDEX_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_SOUTH_LAT:  cfg_prdata = 32'(south_lat_r);
      REG_WEST_LON:   cfg_prdata = 32'(west_lon_r);
      REG_NORTH_LAT:  cfg_prdata = 32'(north_lat_r);
      REG_EAST_LON:   cfg_prdata = 32'(east_lon_r);
      REG_LAT_POINTS: cfg_prdata = 32'(lat_points_r);
      REG_LON_POINTS: cfg_prdata = 32'(lon_points_r);
      default:        cfg_prdata = '0;
    endcase
  end

  // spans are registered from the box registers and feed the dividers directly
  logic [AXIS_W-1:0] span_lat_r, span_lon_r;
  always_ff @(posedge clk) begin
    span_lat_r <= AXIS_W'(32'(north_lat_r) - 32'(south_lat_r));
    span_lon_r <= AXIS_W'(32'(east_lon_r) - 32'(west_lon_r));
  end

  // whole pipeline advances together unless the output is held
  logic en;
  logic [DEPTH-1:0] vld_r;
  logic [DEPTH-1:0] ins_r;
  assign en        = !vld_r[DEPTH-1] || out_tready;
  assign in_tready = en;

  // box test stage
  logic signed [LAT_W-1:0] p_lat;
  logic signed [LON_W-1:0] p_lon;
  logic                    box_hit;
  logic [AXIS_W-1:0]       d_lat_r, d_lon_r;
  assign p_lat   = in_tdata[LAT_W-1:0];
  assign p_lon   = in_tdata[LAT_W+LON_W-1:LAT_W];
  assign box_hit = (p_lat >= south_lat_r) && (p_lat <= north_lat_r) &&
                   (p_lon >= west_lon_r) && (p_lon <= east_lon_r);

  always_ff @(posedge clk) begin
    if (en) begin
      d_lat_r <= AXIS_W'(32'(p_lat) - 32'(south_lat_r));
      d_lon_r <= AXIS_W'(32'(p_lon) - 32'(west_lon_r));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[DEPTH-2:0], in_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ins_r <= {ins_r[DEPTH-2:0], box_hit};
    end
  end

  logic [INDEX_BITS-1:0] lat_idx, lon_idx;
  logic [AXIS_W-1:0]     lat_off, lon_off;

  gcl_axis #(.W(AXIS_W), .IB(INDEX_BITS)) u_lat (
    .clk  (clk),
    .en   (en),
    .d    (d_lat_r),
    .span (span_lat_r),
    .pts  (lat_points_r),
    .idx  (lat_idx),
    .off  (lat_off)
  );

  gcl_axis #(.W(AXIS_W), .IB(INDEX_BITS)) u_lon (
    .clk  (clk),
    .en   (en),
    .d    (d_lon_r),
    .span (span_lon_r),
    .pts  (lon_points_r),
    .idx  (lon_idx),
    .off  (lon_off)
  );

  // outside points: drop everything to zero
  logic in_box;
  assign in_box     = ins_r[DEPTH-1];
  assign out_tvalid = vld_r[DEPTH-1];
  assign out_tuser  = in_box;
  assign out_tdata  = in_box ?
      OUT_W'({lon_off[LON_W-1:0], lat_off[LAT_W-1:0], lon_idx, lat_idx}) : '0;

endmodule
